// File: sv/bdd_unt_pkg.sv
// Package for the decision diagram unique node table: sizes, codes and shared types.
package bdd_unt_pkg;

  // table sizing
  localparam int TABLE_DEPTH = 256;
  localparam int VAR_BITS    = 6;
  localparam int CHILD_W     = 8;
  localparam int NODE_W      = 8;
  localparam int ID_W        = $clog2(TABLE_DEPTH);
  localparam int NEXT_W      = ID_W + 1;
  localparam int KEY_W       = VAR_BITS + 2 * CHILD_W;
  localparam int FIRST_ID    = 2;
  localparam int NUM_CELLS   = TABLE_DEPTH - FIRST_ID;

  // stream layout
  localparam int S_DATA_W = ((KEY_W + 7) / 8) * 8;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = NODE_W;
  localparam int M_USER_W = 2;

  typedef enum logic {
    OP_MAKE  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_e;

  // search token handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic             hit;
    logic             is_new;
    logic [ID_W-1:0]  id;
  } tok_t;

  // finished result waiting for the output register
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              is_new;
    logic              full;
  } res_t;

endpackage

// File: sv/bdd_unt_cell.sv
// One table cell: holds one stored triple and passes the search token to its neighbor.
module bdd_unt_cell
  import bdd_unt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ID_W-1:0]   cell_id_i,
  input  logic [NEXT_W-1:0] next_id_i,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  logic [KEY_W-1:0]  entry_q, entry_d;
  tok_t              tok_q, tok_d;
  logic [NEXT_W-1:0] my_id;
  logic              live;
  logic              wr_en;

  assign my_id = {1'b0, cell_id_i};
  assign live  = my_id < next_id_i;

  // compare against the stored triple, or claim this slot if it is the next free one
  always_comb begin
    tok_d = tok_i;
    wr_en = 1'b0;
    if (tok_i.vld && !tok_i.hit) begin
      if (live && (entry_q == tok_i.key)) begin
        tok_d.hit = 1'b1;
        tok_d.id  = cell_id_i;
      end else if (my_id == next_id_i) begin
        tok_d.hit    = 1'b1;
        tok_d.is_new = 1'b1;
        tok_d.id     = cell_id_i;
        wr_en        = 1'b1;
      end
    end
  end

  assign entry_d = wr_en ? tok_i.key : entry_q;

  // stored triple, undefined until written
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: sv/bdd_unt_ctrl.sv
// Request controller: decodes requests, launches searches, keeps the next free id and output.
module bdd_unt_ctrl
  import bdd_unt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  input  logic [S_USER_W-1:0] s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,
  output logic [M_USER_W-1:0] m_axis_tuser,
  output tok_t                inject_o,
  output logic [NEXT_W-1:0]   next_id_o,
  input  tok_t                tail_i
);

  state_e              state_q, state_d;
  logic [NEXT_W-1:0]   next_id_q, next_id_d;
  res_t                res_q, res_d;
  logic                m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0] m_data_q, m_data_d;
  logic [M_USER_W-1:0] m_user_q, m_user_d;

  op_e                 op;
  logic [VAR_BITS-1:0] var_idx;
  logic [CHILD_W-1:0]  lo_child;
  logic [CHILD_W-1:0]  hi_child;
  logic                out_free;
  logic                accept;

  // request fields
  assign op       = op_e'(s_axis_tuser[0]);
  assign var_idx  = s_axis_tdata[VAR_BITS-1:0];
  assign lo_child = s_axis_tdata[VAR_BITS +: CHILD_W];
  assign hi_child = s_axis_tdata[VAR_BITS+CHILD_W +: CHILD_W];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // next state, search launch and output loading
  always_comb begin
    state_d   = state_q;
    next_id_d = next_id_q;
    res_d     = res_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    inject_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_CLEAR) begin
            next_id_d = NEXT_W'(FIRST_ID);
            m_valid_d = 1'b1;
            m_data_d  = '0;
            m_user_d  = '0;
          end else if (lo_child == hi_child) begin
            m_valid_d = 1'b1;
            m_data_d  = M_DATA_W'(lo_child);
            m_user_d  = '0;
          end else begin
            inject_o.vld = 1'b1;
            inject_o.key = {var_idx, lo_child, hi_child};
            state_d      = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (tail_i.vld) begin
          res_d.node   = tail_i.hit ? NODE_W'(tail_i.id) : '0;
          res_d.is_new = tail_i.is_new;
          res_d.full   = !tail_i.hit;
          if (tail_i.is_new) begin
            next_id_d = NEXT_W'(next_id_q + 1'b1);
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = M_DATA_W'(res_q.node);
          m_user_d  = {res_q.full, res_q.is_new};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      next_id_q <= NEXT_W'(FIRST_ID);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      next_id_q <= next_id_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign next_id_o     = next_id_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // a token leaves the chain only while a search is in flight
  a_tail_in_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_i.vld |-> (state_q == ST_SEARCH))
    else $error("search token left the chain outside a search");

  // the next free id stays within the table
  a_next_id_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_id_q >= NEXT_W'(FIRST_ID)) && (next_id_q <= NEXT_W'(TABLE_DEPTH)))
    else $error("next free id out of range");

  // a miss without insert only happens on a full table
  a_miss_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_i.vld && !tail_i.hit) |-> (next_id_q == NEXT_W'(TABLE_DEPTH)))
    else $error("search missed with free slots left");

  // an insert bumps the next free id by one
  a_insert_bumps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && tail_i.vld && tail_i.is_new)
      |=> (next_id_q == NEXT_W'($past(next_id_q) + 1'b1)))
    else $error("insert did not advance the next free id");

endmodule

// File: sv/bdd_unt_top.sv
// Search path: a make request with distinct children launches a token on acceptance;
// the token walks one cell per cycle down the chain of TABLE_DEPTH - 2 cells, then the
// controller registers the tail result and loads the output register once it is free.
// Clear and equal-children requests return in the cycle after acceptance.
// One request at a time: a new one is accepted only once the last result is loaded.
// Reset: control state cleared and next free id set to 2; stored triples undefined.
// Top level of the decision diagram unique node table: controller and chain of cells.
module bdd_unique_node_table_top
  import bdd_unt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // var_index, low_child, high_child, zero pad
  input  logic [S_USER_W-1:0] s_axis_tuser,  // opcode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,  // node_id
  output logic [M_USER_W-1:0] m_axis_tuser   // was_new, status
);

  tok_t              tok [NUM_CELLS+1];
  logic [NEXT_W-1:0] next_id;

  // request control
  bdd_unt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .inject_o      (tok[0]),
    .next_id_o     (next_id),
    .tail_i        (tok[NUM_CELLS])
  );

  // chain of cells, one per storable id
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    bdd_unt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (ID_W'(g + FIRST_ID)),
      .next_id_i (next_id),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1])
    );
  end

endmodule

// File: tb/sv/tb_bdd_unique_node_table_top.sv
// Testbench for the unique node table: directed, table-full and random request traffic.
`timescale 1ns / 100ps

module tb_bdd_unique_node_table_top;
  import bdd_unt_pkg::*;

  // one make or clear request as the sender sees it
  typedef struct packed {
    op_e                 op;
    logic [VAR_BITS-1:0] var_idx;
    logic [CHILD_W-1:0]  lo_id;
    logic [CHILD_W-1:0]  hi_id;
  } node_req_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;  // var_index, low_child, high_child, zero pad
  logic [S_USER_W-1:0] s_axis_tuser = '0;  // opcode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;       // node_id
  logic [M_USER_W-1:0] m_axis_tuser;       // was_new, status

  // traffic shaping, percent per cycle
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count      = 0;

  // predictor state: own copy of the table
  logic [KEY_W-1:0] triple_store [TABLE_DEPTH];
  int unsigned      next_free = FIRST_ID;
  res_t             node_results_q [$];

  bdd_unique_node_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // hash-cons lookup and insert, one request
  function automatic res_t predict_node(input op_e op, input logic [VAR_BITS-1:0] v,
                                        input logic [CHILD_W-1:0] lo,
                                        input logic [CHILD_W-1:0] hi);
    res_t             r;
    logic [KEY_W-1:0] key;
    int unsigned      limit;
    r = '0;
    if (op == OP_CLEAR) begin
      next_free = FIRST_ID;
      return r;
    end
    if (lo == hi) begin
      r.node = lo;
      return r;
    end
    key   = {v, lo, hi};
    limit = (next_free > TABLE_DEPTH) ? TABLE_DEPTH : next_free;
    for (int unsigned id = FIRST_ID; id < limit; id++) begin
      if (triple_store[id] == key) begin
        r.node = NODE_W'(id);
        return r;
      end
    end
    if (next_free >= TABLE_DEPTH) begin
      r.full = 1'b1;
      return r;
    end
    triple_store[next_free] = key;
    r.node   = NODE_W'(next_free);
    r.is_new = 1'b1;
    next_free++;
    return r;
  endfunction

  // request side predicts, result side checks against the oldest prediction
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        node_results_q = {node_results_q,
                          predict_node(op_e'(s_axis_tuser[0]),
                                       s_axis_tdata[VAR_BITS-1:0],
                                       s_axis_tdata[VAR_BITS +: CHILD_W],
                                       s_axis_tdata[VAR_BITS+CHILD_W +: CHILD_W])};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (node_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result node_id %0d", m_axis_tdata));
        end else begin
          want = node_results_q.pop_front();
          if (m_axis_tdata !== want.node)
            report_mismatch($sformatf("node_id got %0d want %0d", m_axis_tdata, want.node));
          if (m_axis_tuser[0] !== want.is_new)
            report_mismatch($sformatf("was_new got %b want %b (node %0d)",
                                      m_axis_tuser[0], want.is_new, want.node));
          if (m_axis_tuser[1] !== want.full)
            report_mismatch($sformatf("status got %b want %b (node %0d)",
                                      m_axis_tuser[1], want.full, want.node));
        end
      end
    end
  end

  function automatic node_req_t node_req(input op_e op, input int unsigned v,
                                         input int unsigned lo, input int unsigned hi);
    node_req_t rq;
    rq.op      = op;
    rq.var_idx = VAR_BITS'(v);
    rq.lo_id   = CHILD_W'(lo);
    rq.hi_id   = CHILD_W'(hi);
    return rq;
  endfunction

  // drive one request from a falling edge, return at the falling edge after acceptance
  task automatic send_request(input node_req_t rq);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct > 0 && gap < 30 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      gap++;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'({rq.hi_id, rq.lo_id, rq.var_idx});
    s_axis_tuser  <= rq.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // short directed list: hits, misses, equal children, clear, odd bit patterns
  task automatic test_basic_requests();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(node_req(OP_CLEAR, 0, 0, 0));
    send_request(node_req(OP_MAKE, 0, 0, 1));      // first stored id
    send_request(node_req(OP_MAKE, 0, 0, 1));      // hit
    send_request(node_req(OP_MAKE, 0, 1, 0));      // swapped children differ
    send_request(node_req(OP_MAKE, 63, 255, 0));   // children not allocated
    send_request(node_req(OP_MAKE, 63, 0, 255));
    send_request(node_req(OP_MAKE, 1, 0, 1));      // only the variable differs
    send_request(node_req(OP_MAKE, 5, 7, 7));      // equal children
    send_request(node_req(OP_MAKE, 63, 255, 255));
    send_request(node_req(OP_MAKE, 0, 0, 0));
    send_request(node_req(OP_MAKE, 0, 0, 1));
    send_request(node_req(OP_MAKE, 63, 255, 0));
    send_request(node_req(OP_MAKE, 0, 1, 255));
    send_request(node_req(OP_MAKE, 42, 170, 85));
    send_request(node_req(OP_MAKE, 21, 85, 170));
    send_request(node_req(OP_CLEAR, 63, 255, 255));
    send_request(node_req(OP_MAKE, 0, 0, 1));      // stored again after clear
    send_request(node_req(OP_CLEAR, 0, 0, 0));
    send_request(node_req(OP_CLEAR, 0, 0, 0));
    send_request(node_req(OP_MAKE, 42, 170, 85));
  endtask

  // fill every id, then miss, hit and equal children on a full table
  task automatic test_table_full();
    node_req_t first_rq;
    node_req_t last_rq;
    node_req_t rq;
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    send_request(node_req(OP_CLEAR, 0, 0, 0));
    for (int unsigned i = 0; i < TABLE_DEPTH - FIRST_ID; i++) begin
      rq = node_req(OP_MAKE, i % 64, i / 64, $urandom_range(4, 255));
      if (i == 0) first_rq = rq;
      last_rq = rq;
      send_request(rq);
    end
    send_request(node_req(OP_MAKE, 0, 3, 2));      // miss while full
    send_request(node_req(OP_MAKE, 63, 3, 1));
    send_request(last_rq);                         // hit on the top id
    send_request(first_rq);
    send_request(node_req(OP_MAKE, 9, 200, 200));  // equal children while full
    send_request(node_req(OP_CLEAR, 0, 0, 0));
    send_request(last_rq);
  endtask

  function automatic int unsigned pick_child(input int unsigned made);
    int unsigned bound;
    if ($urandom_range(9) == 0) return $urandom_range(255);
    bound = made + 1;
    if (bound > 255) bound = 255;
    return $urandom_range(bound);
  endfunction

  // episodes that build diagrams from earlier ids, with repeats and noise
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_items, input bit fill_first);
    node_req_t   made_q [$];
    node_req_t   rq;
    int unsigned sent;
    int unsigned ep_len;
    int unsigned r;
    int unsigned lo;
    bit          filling;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent    = 0;
    filling = fill_first;
    while (sent < n_items) begin
      send_request(node_req(OP_CLEAR, $urandom_range(63), $urandom_range(255),
                            $urandom_range(255)));
      sent++;
      made_q.delete();
      ep_len  = filling ? 300 : $urandom_range(8, 60);
      for (int unsigned k = 0; k < ep_len && sent < n_items; k++) begin
        r = filling ? $urandom_range(84) : $urandom_range(99);
        if (r >= 60 && r < 85 && made_q.size() > 0) begin
          rq = made_q[$urandom_range(made_q.size() - 1)];
        end else if (r < 85) begin
          lo = pick_child(made_q.size());
          rq = node_req(OP_MAKE, $urandom_range(63), lo, pick_child(made_q.size()));
          if (rq.lo_id == rq.hi_id) rq.hi_id = rq.lo_id ^ 8'h01;
          made_q = {made_q, rq};
        end else if (r < 93) begin
          lo = $urandom_range(255);
          rq = node_req(OP_MAKE, $urandom_range(63), lo, lo);
        end else if (r < 98) begin
          rq = node_req(OP_MAKE, $urandom_range(63), $urandom_range(255), $urandom_range(255));
        end else begin
          rq = node_req(OP_CLEAR, $urandom_range(63), $urandom_range(255), $urandom_range(255));
          made_q.delete();
        end
        send_request(rq);
        sent++;
      end
      filling = 1'b0;
    end
  endtask

  // test sequence
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_basic_requests();
    test_table_full();
    test_random_traffic(0, 0, 340, 1'b0);
    test_random_traffic(82, 0, 340, 1'b0);
    test_random_traffic(0, 82, 340, 1'b1);
    test_random_traffic(9, 9, 340, 1'b1);
    s_axis_tvalid <= 1'b0;
    while (node_results_q.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 16) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS bdd_unique_node_table_top");
    end else begin
      $display("FAIL bdd_unique_node_table_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("FAIL bdd_unique_node_table_top");
    $finish;
  end

endmodule

// File: bdd_unique_node_table_top.f
sv/bdd_unt_pkg.sv
sv/bdd_unt_cell.sv
sv/bdd_unt_ctrl.sv
sv/bdd_unt_top.sv
tb/sv/tb_bdd_unique_node_table_top.sv
